### hdl/stapg_pkg.sv
// ----------------------------------------------------------------------------
// stapg_pkg: shared types and tables for the arc pixel generator
// Request/result payloads, action codes, quarter-sine table, scaling constants.
// ----------------------------------------------------------------------------
package stapg_pkg;

  // action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_NEXT  = 1'b1;

  localparam int QUARTER_STEPS = 64;
  localparam int SINE_DEPTH    = QUARTER_STEPS + 1;
  localparam int SINE_W        = 11;
  localparam int UNIT_W        = SINE_W + 1;
  localparam int RAY_W         = 10;
  localparam int STEP_W        = 9;
  localparam int COORD_W       = 16;
  localparam int FRAC_BITS     = 10;

  localparam logic [6:0]  PCT_MAX   = 7'd100;
  // floor(p*256/100) == (p*5243) >> 11 for every p in 0..100
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          RECIP_SH  = 11;

  localparam logic [SINE_W-1:0] SINE_QUARTER [SINE_DEPTH] = '{
    11'd0,    11'd25,   11'd50,   11'd75,   11'd100,  11'd125,  11'd150,  11'd175,
    11'd200,  11'd224,  11'd249,  11'd273,  11'd297,  11'd321,  11'd345,  11'd369,
    11'd392,  11'd415,  11'd438,  11'd460,  11'd483,  11'd505,  11'd526,  11'd548,
    11'd569,  11'd590,  11'd610,  11'd630,  11'd650,  11'd669,  11'd688,  11'd706,
    11'd724,  11'd742,  11'd759,  11'd775,  11'd792,  11'd807,  11'd822,  11'd837,
    11'd851,  11'd865,  11'd878,  11'd891,  11'd903,  11'd915,  11'd926,  11'd936,
    11'd946,  11'd955,  11'd964,  11'd972,  11'd980,  11'd987,  11'd993,  11'd999,
    11'd1004, 11'd1009, 11'd1013, 11'd1016, 11'd1019, 11'd1021, 11'd1023, 11'd1024,
    11'd1024
  };

  typedef struct packed {
    logic               action;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [7:0]         radius;
    logic [7:0]         ring_thickness;
    logic [7:0]         fill_percent;
  } in_item_t;

  typedef struct packed {
    logic               pixel_valid;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               last_pixel;
  } out_item_t;

  // one request as it leaves the state stage
  typedef struct packed {
    logic                     pix;
    logic                     last;
    logic [STEP_W-1:0]        step;
    logic signed [RAY_W-1:0]  ray;
    logic [COORD_W-1:0]       cx;
    logic [COORD_W-1:0]       cy;
  } pix_req_t;

endpackage

### hdl/stapg_pixel_calc.sv
// ----------------------------------------------------------------------------
// stapg_pixel_calc: unit vector lookup and ring offset
// Mirrors the quarter-sine table into four quadrants, scales by the ray and
// adds the rounded offset to the centre.
// ----------------------------------------------------------------------------
module stapg_pixel_calc (
  input  stapg_pkg::pix_req_t  req,
  output stapg_pkg::out_item_t res
);

  localparam int UW = stapg_pkg::UNIT_W;
  localparam int RW = stapg_pkg::RAY_W;
  localparam int PW = UW + RW;
  localparam int FB = stapg_pkg::FRAC_BITS;
  localparam int OW = PW - FB;
  localparam int CW = stapg_pkg::COORD_W;

  logic [1:0]           quad;
  logic [5:0]           w;
  logic signed [UW-1:0] s_val;
  logic signed [UW-1:0] c_val;
  logic signed [UW-1:0] ux;
  logic signed [UW-1:0] uy;
  logic [CW-1:0]        px;
  logic [CW-1:0]        py;

  function automatic logic [CW-1:0] place(input logic [CW-1:0] centre,
                                          input logic signed [UW-1:0] unit,
                                          input logic signed [RW-1:0] ray);
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] rnd;
    logic signed [OW-1:0] off;
    prod = unit * ray;
    rnd  = prod + PW'(1 << (FB - 1));
    off  = rnd[PW-1:FB];
    // the shift floors; to round toward zero, bump negative values with a remainder
    if (rnd[PW-1] && (rnd[FB-1:0] != '0)) begin
      off = off + OW'(1);
    end
    return centre + {{(CW-OW){off[OW-1]}}, off};
  endfunction

  assign quad  = req.step[7:6];
  assign w     = req.step[5:0];
  assign s_val = {1'b0, stapg_pkg::SINE_QUARTER[{1'b0, w}]};
  assign c_val = {1'b0, stapg_pkg::SINE_QUARTER[7'(stapg_pkg::QUARTER_STEPS) - {1'b0, w}]};

  always_comb begin
    case (quad)
      2'd0: begin
        ux = s_val;
        uy = -c_val;
      end
      2'd1: begin
        ux = c_val;
        uy = s_val;
      end
      2'd2: begin
        ux = -s_val;
        uy = c_val;
      end
      default: begin
        ux = -c_val;
        uy = -s_val;
      end
    endcase
  end

  assign px = place(req.cx, ux, req.ray);
  assign py = place(req.cy, uy, req.ray);

  always_comb begin
    res.pixel_valid = req.pix;
    res.last_pixel  = req.last;
    res.pixel_x     = req.pix ? px : '0;
    res.pixel_y     = req.pix ? py : '0;
  end

endmodule

### hdl/sine_table_arc_pixel_generator.sv
// ----------------------------------------------------------------------------
// sine_table_arc_pixel_generator: thick ring arc rasterizer
// Start requests latch an arc; next requests emit its pixels one at a time.
// ----------------------------------------------------------------------------
// Takes one request per clock unless the output stalls and presents one result
// per request; the request is held in the first stage register and the result
// in the output register. A start request latches the centre and ring radii
// and answers with an empty result (last_pixel set when the thickness is zero);
// each next request on an active arc walks the ring radius by radius, then the
// angle in 256 steps per turn clockwise from the top, and answers with one
// pixel. The first stage updates the arc state and the second does the table
// lookup, the scaling multiply and the centre add, so the rate is one request
// per clock when unstalled; the multiply-and-add path sets the clock period.
// A stalled output holds the input off only once both stages are full.
module sine_table_arc_pixel_generator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  stapg_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output stapg_pkg::out_item_t out_data
);

  localparam int RW = stapg_pkg::RAY_W;
  localparam int SW = stapg_pkg::STEP_W;
  localparam int CW = stapg_pkg::COORD_W;

  logic [CW-1:0]        held_cx_r, held_cy_r;
  logic signed [RW-1:0] inner_ray_r, outer_ray_r, cur_ray_r;
  logic [SW-1:0]        step_r, final_step_r;
  logic                 busy_r;

  logic                 s1_valid_r;
  stapg_pkg::pix_req_t  s1_req_r;
  stapg_pkg::pix_req_t  req_nxt;
  logic                 out_valid_r;
  stapg_pkg::out_item_t out_data_r;
  stapg_pkg::out_item_t calc_res;

  logic                 in_acc;
  logic                 out_free;
  logic                 is_start;
  logic [6:0]           pct_sat;
  logic [19:0]          pct_prod;
  logic [RW-1:0]        half_w;
  logic signed [RW-1:0] inner_nxt, outer_nxt;
  logic                 last_hit;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_free;
  assign in_acc   = in_valid && in_ready;
  assign is_start = (in_data.action == stapg_pkg::ACT_START);

  assign pct_sat   = (in_data.fill_percent > {1'b0, stapg_pkg::PCT_MAX}) ?
                     stapg_pkg::PCT_MAX : in_data.fill_percent[6:0];
  assign pct_prod  = 20'(pct_sat) * 20'(stapg_pkg::RECIP_100);
  assign half_w    = RW'(in_data.ring_thickness[7:1]);
  assign inner_nxt = RW'(in_data.radius) - half_w;
  assign outer_nxt = RW'(in_data.radius) + RW'(in_data.ring_thickness) - RW'(1) - half_w;
  assign last_hit  = (step_r == final_step_r) && (cur_ray_r == outer_ray_r);

  always_comb begin
    req_nxt = '0;
    if (is_start) begin
      req_nxt.last = (in_data.ring_thickness == '0);
    end else if (busy_r) begin
      req_nxt.pix  = 1'b1;
      req_nxt.last = last_hit;
      req_nxt.step = step_r;
      req_nxt.ray  = cur_ray_r;
      req_nxt.cx   = held_cx_r;
      req_nxt.cy   = held_cy_r;
    end
  end

  // arc state advances as each request is accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cx_r    <= '0;
      held_cy_r    <= '0;
      inner_ray_r  <= '0;
      outer_ray_r  <= '0;
      cur_ray_r    <= '0;
      step_r       <= '0;
      final_step_r <= '0;
      busy_r       <= 1'b0;
    end else if (in_acc) begin
      if (is_start) begin
        held_cx_r    <= in_data.center_x;
        held_cy_r    <= in_data.center_y;
        inner_ray_r  <= inner_nxt;
        outer_ray_r  <= outer_nxt;
        cur_ray_r    <= inner_nxt;
        step_r       <= '0;
        final_step_r <= pct_prod[stapg_pkg::RECIP_SH +: SW];
        busy_r       <= (in_data.ring_thickness != '0);
      end else if (busy_r) begin
        if (last_hit) begin
          busy_r <= 1'b0;
        end else if (cur_ray_r >= outer_ray_r) begin
          cur_ray_r <= inner_ray_r;
          step_r    <= step_r + SW'(1);
        end else begin
          cur_ray_r <= cur_ray_r + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= req_nxt;
    end
  end

  stapg_pixel_calc u_calc (
    .req (s1_req_r),
    .res (calc_res)
  );

  // hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_data_r <= calc_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
